// ----- rtl/gdc_pkg.sv -----
package gdc_pkg;

  localparam int unsigned YEAR_BITS_DEF = 14;
  localparam int unsigned STEP_BITS_DEF = 16;
  localparam int unsigned RESET_YEAR    = 2000;

  // item kinds (tuser)
  localparam logic [1:0] KIND_SET     = 2'd0;
  localparam logic [1:0] KIND_ADVANCE = 2'd1;
  localparam logic [1:0] KIND_COMPARE = 2'd2;

  // compare results
  localparam logic [1:0] ORD_SAME    = 2'd0;
  localparam logic [1:0] ORD_EARLIER = 2'd1;
  localparam logic [1:0] ORD_LATER   = 2'd2;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;
  localparam logic [4:0] DAY_FIRST = 5'd1;
  localparam logic [4:0] DAY_LAST  = 5'd31;

  // divisibility by 25 on a 16-bit value: y * inv(25) mod 2^16 <= floor(0xFFFF / 25)
  localparam logic [15:0] INV25     = 16'd23593;
  localparam logic [15:0] DIV25_LIM = 16'd2621;

  // Days in month m; 0 for a month outside 1..12.
  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] d;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
      4'd2:                                        d = leap ? 5'd29 : 5'd28;
      default:                                     d = 5'd0;
    endcase
    return d;
  endfunction

  // Days in the months before m, February taken as 28 days.
  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] d;
    case (m)
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

// ----- rtl/gregorian_date_counter.sv -----
// Channel   Dir  Handshake                       Payload
// s_axis    in   s_axis_tvalid / s_axis_tready   tuser: kind; tdata: month, day, year, step
// m_axis    out  m_axis_tvalid / m_axis_tready   tdata: date, day of year, flags
//
// Set and compare pass from the request through their own state and ST_FIN to the
// result register. An advance steps through ST_ADV once per month boundary crossed,
// visits ST_LEAP at each year boundary, and ends through ST_ADV and ST_FIN.
// The output register lets the next request in while a result waits; a stalled
// result holds the block in ST_FIN. Reset gives 1/1/2000, no result.
module gregorian_date_counter import gdc_pkg::*; #(
  parameter int unsigned YEAR_BITS = YEAR_BITS_DEF,
  parameter int unsigned STEP_BITS = STEP_BITS_DEF,
  localparam int unsigned OUT_W  = 22 + YEAR_BITS,
  localparam int unsigned OUT_TW = ((OUT_W + 7) / 8) * 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // [3:0] in_month, [8:4] in_day, [22:9] in_year, [38:23] step_days, [39] zero
  input  logic [39:0]       s_axis_tdata,
  // [1:0] kind
  input  logic [1:0]        s_axis_tuser,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // cur_month, cur_day, cur_year, day_of_year, accepted, order, year_overflow, zeros
  output logic [OUT_TW-1:0] m_axis_tdata
);

  localparam int unsigned CW = (STEP_BITS > 6) ? STEP_BITS : 6;
  localparam logic [YEAR_BITS-1:0] YEAR_MAX = {YEAR_BITS{1'b1}};

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SET  = 3'd1;
  localparam logic [2:0] ST_ADV  = 3'd2;
  localparam logic [2:0] ST_LEAP = 3'd3;
  localparam logic [2:0] ST_CMP  = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  logic [2:0]           state_q, state_d;
  logic [3:0]           month_q, month_d;
  logic [4:0]           day_q, day_d;
  logic [YEAR_BITS-1:0] year_q, year_d;
  logic                 leap_q, leap_d;
  logic [3:0]           gm_q, gm_d;
  logic [4:0]           gd_q, gd_d;
  logic [13:0]          gy_q, gy_d;
  logic [STEP_BITS-1:0] n_q, n_d;
  logic                 acc_q, acc_d;
  logic [1:0]           ord_q, ord_d;
  logic                 ovf_q, ovf_d;
  logic                 out_valid_q, out_valid_d;
  logic [OUT_TW-1:0]    out_data_q, out_data_d;

  logic                     in_fire;
  logic [YEAR_BITS+13:0]    gy_ext;
  logic [YEAR_BITS+13:0]    yq_ext;

  // shared leap unit: given year during set, stored year after a year carry
  logic [15:0] leap_in;
  logic [15:0] leap_prod;
  logic        leap_out;

  logic [4:0]    mlen_g, mlen_c, left;
  logic [CW-1:0] n_ext, left_ext;
  logic          set_ok;
  logic [8:0]    doy;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign gy_ext   = {{YEAR_BITS{1'b0}}, gy_q};
  assign yq_ext   = {14'd0, year_q};

  assign leap_in   = (state_q == ST_SET) ? {2'b00, gy_q} : 16'(year_q);
  assign leap_prod = leap_in * INV25;
  assign leap_out  = (leap_in[1:0] == 2'b00) &&
                     ((leap_prod > DIV25_LIM) || (leap_in[3:0] == 4'd0));

  assign mlen_g   = month_days(gm_q, leap_out);
  assign set_ok   = (gd_q != 5'd0) && (gd_q <= mlen_g) &&
                    (gy_ext[YEAR_BITS+13:YEAR_BITS] == 14'd0);

  assign mlen_c   = month_days(month_q, leap_q);
  assign left     = mlen_c - day_q;
  assign n_ext    = CW'(n_q);
  assign left_ext = CW'(left);

  assign doy = days_before(month_q) + 9'(day_q) +
               9'(leap_q && (month_q > MONTH_FEB));

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  always_comb begin
    state_d     = state_q;
    month_d     = month_q;
    day_d       = day_q;
    year_d      = year_q;
    leap_d      = leap_q;
    gm_d        = gm_q;
    gd_d        = gd_q;
    gy_d        = gy_q;
    n_d         = n_q;
    acc_d       = acc_q;
    ord_d       = ord_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          gm_d  = s_axis_tdata[3:0];
          gd_d  = s_axis_tdata[8:4];
          gy_d  = s_axis_tdata[22:9];
          n_d   = STEP_BITS'(s_axis_tdata[38:23]);
          acc_d = 1'b0;
          ord_d = ORD_SAME;
          ovf_d = 1'b0;
          case (s_axis_tuser)
            KIND_SET:     state_d = ST_SET;
            KIND_ADVANCE: state_d = ST_ADV;
            KIND_COMPARE: state_d = ST_CMP;
            default:      state_d = ST_FIN;
          endcase
        end
      end
      ST_SET: begin
        if (set_ok) begin
          month_d = gm_q;
          day_d   = gd_q;
          year_d  = gy_ext[YEAR_BITS-1:0];
          leap_d  = leap_out;
          acc_d   = 1'b1;
        end
        state_d = ST_FIN;
      end
      ST_ADV: begin
        if (n_ext <= left_ext) begin
          day_d   = day_q + n_ext[4:0];
          state_d = ST_FIN;
        end else if ((month_q == MONTH_DEC) && (year_q == YEAR_MAX)) begin
          day_d   = DAY_LAST;
          ovf_d   = 1'b1;
          state_d = ST_FIN;
        end else begin
          n_d   = STEP_BITS'(n_ext - left_ext - CW'(1));
          day_d = DAY_FIRST;
          if (month_q == MONTH_DEC) begin
            month_d = MONTH_JAN;
            year_d  = year_q + YEAR_BITS'(1);
            state_d = ST_LEAP;
          end else begin
            month_d = month_q + 4'd1;
          end
        end
      end
      ST_LEAP: begin
        leap_d  = leap_out;
        state_d = ST_ADV;
      end
      ST_CMP: begin
        if (gy_ext != yq_ext) begin
          ord_d = (gy_ext < yq_ext) ? ORD_EARLIER : ORD_LATER;
        end else if (gm_q != month_q) begin
          ord_d = (gm_q < month_q) ? ORD_EARLIER : ORD_LATER;
        end else if (gd_q != day_q) begin
          ord_d = (gd_q < day_q) ? ORD_EARLIER : ORD_LATER;
        end
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = {(OUT_TW - OUT_W)'(0), ovf_q, ord_q, acc_q, doy,
                         year_q, day_q, month_q};
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      month_q     <= MONTH_JAN;
      day_q       <= DAY_FIRST;
      year_q      <= YEAR_BITS'(RESET_YEAR);
      leap_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      month_q     <= month_d;
      day_q       <= day_d;
      year_q      <= year_d;
      leap_q      <= leap_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    gm_q       <= gm_d;
    gd_q       <= gd_d;
    gy_q       <= gy_d;
    n_q        <= n_d;
    acc_q      <= acc_d;
    ord_q      <= ord_d;
    ovf_q      <= ovf_d;
    out_data_q <= out_data_d;
  end

endmodule

// ----- rtl/gdc_checker.sv -----
module gdc_checker import gdc_pkg::*; #(
  parameter int unsigned YEAR_BITS = YEAR_BITS_DEF,
  localparam int unsigned OUT_W  = 22 + YEAR_BITS,
  localparam int unsigned OUT_TW = ((OUT_W + 7) / 8) * 8
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_axis_tvalid,
  input logic              s_axis_tready,
  input logic [39:0]       s_axis_tdata,
  input logic [1:0]        s_axis_tuser,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [OUT_TW-1:0] m_axis_tdata
);

  logic [3:0] cur_month;
  logic [4:0] cur_day;
  logic [8:0] doy;
  logic       acc, ovf;
  logic [1:0] ord;

  assign cur_month = m_axis_tdata[3:0];
  assign cur_day   = m_axis_tdata[8:4];
  assign doy       = m_axis_tdata[17+YEAR_BITS:9+YEAR_BITS];
  assign acc       = m_axis_tdata[18+YEAR_BITS];
  assign ord       = m_axis_tdata[20+YEAR_BITS:19+YEAR_BITS];
  assign ovf       = m_axis_tdata[21+YEAR_BITS];

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // one request at a time
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while busy");

  a_date_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (cur_month != 4'd0) && (cur_month <= MONTH_DEC) &&
                      (cur_day != 5'd0) && (doy != 9'd0) && (doy <= 9'd366))
    else $error("stored date out of range");

  // at most one flag group per result
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(acc && ovf) && !(acc && (ord != ORD_SAME)) &&
                      !(ovf && (ord != ORD_SAME)) &&
                      ((ord == ORD_SAME) || (ord == ORD_EARLIER) || (ord == ORD_LATER)))
    else $error("conflicting result flags");

endmodule

bind gregorian_date_counter gdc_checker #(.YEAR_BITS(YEAR_BITS)) u_gdc_checker (.*);

// ----- tb/sv/gdc_checker.sv -----
module gdc_scoreboard import gdc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  input  logic              req_ready_i,
  // [3:0] in_month, [8:4] in_day, [22:9] in_year, [38:23] step_days, [39] zero
  input  logic [39:0]       req_data_i,
  // [1:0] kind
  input  logic [1:0]        req_kind_i,
  input  logic              rsp_valid_i,
  input  logic              rsp_ready_i,
  // cur_month, cur_day, cur_year, day_of_year, accepted, order, year_overflow, zeros
  input  logic [39:0]       rsp_data_i,
  output int unsigned       fail_count_o,
  output int unsigned       pending_o,
  output int unsigned       checked_o
);

  localparam int unsigned YW       = YEAR_BITS_DEF;
  localparam int unsigned YEAR_MAX = (1 << YW) - 1;
  localparam int unsigned YDAY_LO  = 9 + YW;
  localparam int unsigned FLAG_LO  = YDAY_LO + 9;

  typedef struct packed {
    logic [3:0]    month;
    logic [4:0]    day;
    logic [YW-1:0] year;
    logic [8:0]    yday;
    logic          accepted;
    logic [1:0]    order;
    logic          overflow;
  } date_result_t;

  date_result_t expected_q[$];

  int unsigned cal_month;
  int unsigned cal_day;
  int unsigned cal_year;

  int unsigned fail_cnt    = 0;
  int unsigned seen_cnt    = 0;
  int unsigned pending_cnt = 0;

  assign fail_count_o = fail_cnt;
  assign pending_o    = pending_cnt;
  assign checked_o    = seen_cnt;

  function automatic bit leap_year(input int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic int unsigned month_length(input int unsigned m, input int unsigned y);
    if (m < 1 || m > 12) return 0;
    if (m == 2) return leap_year(y) ? 29 : 28;
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    return 31;
  endfunction

  function automatic int unsigned ordinal_of_date();
    int unsigned total;
    total = cal_day;
    for (int unsigned m = 1; m < cal_month && m <= 12; m++)
      total += month_length(m, cal_year);
    return total;
  endfunction

  // walks month by month; stops at 12/31 of the top year
  function automatic bit advance_days(input int unsigned n);
    int unsigned left;
    while (n > 0) begin
      left = month_length(cal_month, cal_year) - cal_day;
      if (n <= left) begin
        cal_day += n;
        return 1'b0;
      end
      if (cal_month == 12 && cal_year == YEAR_MAX) begin
        cal_day = 31;
        return 1'b1;
      end
      n -= left + 1;
      cal_day = 1;
      cal_month++;
      if (cal_month > 12) begin
        cal_month = 1;
        cal_year++;
      end
    end
    return 1'b0;
  endfunction

  function automatic date_result_t next_calendar_result(input logic [1:0] kind,
                                                        input logic [39:0] data);
    date_result_t res;
    int unsigned gm;
    int unsigned gd;
    int unsigned gy;
    res = '0;
    gm  = 32'(data[3:0]);
    gd  = 32'(data[8:4]);
    gy  = 32'(data[9 +: YW]);
    case (kind)
      KIND_SET: begin
        if (gm >= 1 && gm <= 12 && gd >= 1 && gy <= YEAR_MAX &&
            gd <= month_length(gm, gy)) begin
          cal_month    = gm;
          cal_day      = gd;
          cal_year     = gy;
          res.accepted = 1'b1;
        end
      end
      KIND_ADVANCE: res.overflow = advance_days(32'(data[38:23]));
      KIND_COMPARE: begin
        // raw field order: year, then month, then day
        if (gy != cal_year)
          res.order = (gy < cal_year) ? ORD_EARLIER : ORD_LATER;
        else if (gm != cal_month)
          res.order = (gm < cal_month) ? ORD_EARLIER : ORD_LATER;
        else if (gd != cal_day)
          res.order = (gd < cal_day) ? ORD_EARLIER : ORD_LATER;
        else
          res.order = ORD_SAME;
      end
      default: ;
    endcase
    res.month = 4'(cal_month);
    res.day   = 5'(cal_day);
    res.year  = YW'(cal_year);
    res.yday  = 9'(ordinal_of_date());
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    fail_cnt++;
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want)
      report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                seen_cnt, name, got, want));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    date_result_t want;
    if (!rst_ni) begin
      cal_month = 32'(MONTH_JAN);
      cal_day   = 32'(DAY_FIRST);
      cal_year  = RESET_YEAR;
      expected_q.delete();
      pending_cnt = 0;
    end else begin
      if (rsp_valid_i && rsp_ready_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = expected_q.pop_front();
          check_field("cur_month", 32'(rsp_data_i[3:0]), 32'(want.month));
          check_field("cur_day", 32'(rsp_data_i[8:4]), 32'(want.day));
          check_field("cur_year", 32'(rsp_data_i[9 +: YW]), 32'(want.year));
          check_field("day_of_year", 32'(rsp_data_i[YDAY_LO +: 9]), 32'(want.yday));
          check_field("accepted", 32'(rsp_data_i[FLAG_LO]), 32'(want.accepted));
          check_field("order", 32'(rsp_data_i[FLAG_LO+1 +: 2]), 32'(want.order));
          check_field("year_overflow", 32'(rsp_data_i[FLAG_LO+3]), 32'(want.overflow));
        end
        seen_cnt++;
      end
      if (req_valid_i && req_ready_i)
        expected_q.push_back(next_calendar_result(req_kind_i, req_data_i));
      pending_cnt = expected_q.size();
    end
  end

endmodule

// ----- tb/sv/tb_gregorian_date_counter.sv -----
module tb_gregorian_date_counter import gdc_pkg::*;;

  localparam logic [1:0]  KIND_UNUSED  = 2'd3;
  localparam int unsigned YEAR_TOP     = (1 << YEAR_BITS_DEF) - 1;
  localparam int unsigned RANDOM_ITEMS = 600;
  localparam int unsigned STALL_LIMIT  = 20000;
  localparam int unsigned TAIL_CYCLES  = 10;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = KIND_SET;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;

  int unsigned tx_idle_pct = 12;
  int unsigned rx_idle_pct = 75;
  int unsigned kind_cnt[4] = '{0, 0, 0, 0};
  int unsigned quiet_cycles = 0;

  // last date known to be stored, for compares close to it
  bit          have_date = 1'b0;
  logic [3:0]  kn_month;
  logic [4:0]  kn_day;
  logic [13:0] kn_year;

  always #1 clk_i = ~clk_i;

  gregorian_date_counter u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  gdc_scoreboard u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (s_axis_tvalid),
    .req_ready_i  (s_axis_tready),
    .req_data_i   (s_axis_tdata),
    .req_kind_i   (s_axis_tuser),
    .rsp_valid_i  (m_axis_tvalid),
    .rsp_ready_i  (m_axis_tready),
    .rsp_data_i   (m_axis_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  always @(posedge clk_i) begin
    m_axis_tready <= rst_ni && ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("watchdog: no handshake in %0d cycles", STALL_LIMIT);
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // valid stays up between back-to-back requests
  task automatic send_req(input logic [1:0] kind, input logic [3:0] mon,
                          input logic [4:0] day, input logic [13:0] yr,
                          input logic [15:0] days);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {1'b0, days, yr, day, mon};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    kind_cnt[kind]++;
  endtask

  task automatic random_req();
    int unsigned pick;
    int unsigned sub;
    logic [3:0]  mon;
    logic [4:0]  day;
    logic [13:0] yr;
    logic [15:0] days;
    pick = $urandom_range(99);
    sub  = $urandom_range(99);
    mon  = 4'($urandom_range(15));
    day  = 5'($urandom_range(31));
    yr   = 14'($urandom_range(YEAR_TOP));
    days = 16'($urandom_range(65535));
    if (pick < 30) begin
      // a tenth of the sets land near the top year so advances overflow
      if ($urandom_range(9) == 0) yr = 14'($urandom_range(YEAR_TOP, YEAR_TOP - 3));
      if (sub < 70) begin
        mon       = 4'($urandom_range(12, 1));
        day       = 5'($urandom_range(28, 1));
        have_date = 1'b1;
        kn_month  = mon;
        kn_day    = day;
        kn_year   = yr;
      end else begin
        if (sub < 85) begin
          mon = 4'($urandom_range(12, 1));
          day = 5'($urandom_range(31, 29));
        end
        have_date = 1'b0;
      end
      send_req(KIND_SET, mon, day, yr, days);
    end else if (pick < 70) begin
      if (sub < 70)      days = 16'($urandom_range(40));
      else if (sub < 90) days = 16'($urandom_range(800));
      else if (sub < 97) days = 16'($urandom_range(6000));
      if (days != 0) have_date = 1'b0;
      send_req(KIND_ADVANCE, mon, day, yr, days);
    end else if (pick < 95) begin
      if (have_date && sub < 60) begin
        mon = kn_month;
        day = kn_day;
        yr  = kn_year;
        case ($urandom_range(6))
          1: day = day + 5'd1;
          2: day = day - 5'd1;
          3: mon = mon + 4'd1;
          4: mon = mon - 4'd1;
          5: yr  = yr + 14'd1;
          6: yr  = yr - 14'd1;
          default: ;
        endcase
      end
      send_req(KIND_COMPARE, mon, day, yr, days);
    end else begin
      send_req(KIND_UNUSED, mon, day, yr, days);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_req(KIND_COMPARE, 4'd1, 5'd1, 14'd2000, 16'd0);      // same as reset date
    send_req(KIND_SET, 4'd2, 5'd29, 14'd2000, 16'd0);         // leap by 400
    send_req(KIND_SET, 4'd2, 5'd29, 14'd1900, 16'd0);         // century, not leap
    send_req(KIND_SET, 4'd4, 5'd31, 14'd2021, 16'd0);
    send_req(KIND_SET, 4'd0, 5'd10, 14'd2021, 16'd0);
    send_req(KIND_SET, 4'd15, 5'd31, 14'd16383, 16'd65535);
    send_req(KIND_SET, 4'd6, 5'd0, 14'd2021, 16'd0);
    send_req(KIND_SET, 4'd2, 5'd29, 14'd0, 16'd0);            // year 0 is leap
    send_req(KIND_SET, MONTH_DEC, DAY_LAST, 14'd1999, 16'd0);
    send_req(KIND_ADVANCE, 4'd0, 5'd0, 14'd0, 16'd1);         // year rollover
    send_req(KIND_ADVANCE, 4'd15, 5'd31, 14'd16383, 16'd0);   // zero days
    send_req(KIND_COMPARE, 4'd12, 5'd31, 14'd1999, 16'd0);
    send_req(KIND_COMPARE, 4'd1, 5'd1, 14'd2001, 16'd0);
    send_req(KIND_COMPARE, 4'd2, 5'd1, 14'd2000, 16'd0);
    send_req(KIND_COMPARE, 4'd1, 5'd2, 14'd2000, 16'd0);
    send_req(KIND_COMPARE, 4'd15, 5'd0, 14'd2000, 16'd0);     // invalid, raw order
    send_req(KIND_SET, 4'd2, 5'd28, 14'd2100, 16'd0);
    send_req(KIND_ADVANCE, 4'd0, 5'd0, 14'd0, 16'd1);         // 2100 not leap
    send_req(KIND_SET, MONTH_DEC, DAY_LAST, 14'd16383, 16'd0);
    send_req(KIND_ADVANCE, 4'd0, 5'd0, 14'd0, 16'd1);         // overflow
    send_req(KIND_ADVANCE, 4'd0, 5'd0, 14'd0, 16'd65535);
    send_req(KIND_COMPARE, 4'd12, 5'd30, 14'd16383, 16'd0);
    send_req(KIND_COMPARE, 4'd11, 5'd31, 14'd16383, 16'd0);
    send_req(KIND_UNUSED, 4'd15, 5'd31, 14'd16383, 16'd65535);
    send_req(KIND_SET, MONTH_JAN, DAY_FIRST, 14'd0, 16'd0);
    send_req(KIND_ADVANCE, 4'd15, 5'd31, 14'd16383, 16'd65535);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 3) begin
        tx_idle_pct = 75;
        rx_idle_pct = 12;
      end else if (i == 2 * RANDOM_ITEMS / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      random_req();
    end
    s_axis_tvalid <= 1'b0;

    do @(posedge clk_i); while (pending != 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Sent %0d requests: %0d set, %0d advance, %0d compare, %0d unused kind",
             kind_cnt[0] + kind_cnt[1] + kind_cnt[2] + kind_cnt[3],
             kind_cnt[KIND_SET], kind_cnt[KIND_ADVANCE], kind_cnt[KIND_COMPARE],
             kind_cnt[KIND_UNUSED]);
    $display("Compared %0d results, %0d mismatches", checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/gdc_pkg.sv
rtl/gregorian_date_counter.sv
rtl/gdc_checker.sv
tb/sv/gdc_checker.sv
tb/sv/tb_gregorian_date_counter.sv
